FILE: rtl/core/iirl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants of the indexed insert/remove list
// Request and response item layouts, operation and status codes, and the
// command that the list controller sends to every storage cell.
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int unsigned POS_W          = 7;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned CNT_OUT_W      = 7;
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
    logic [CNT_OUT_W-1:0]    count;
  } rsp_t;

  // Broadcast to all cells in the cycle a request is accepted.
  typedef struct packed {
    logic             en;
    op_e              op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/iirl_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirl_stream_if: valid/ready stream channel
// Carries one item per transaction; the payload type is a parameter.
// ----------------------------------------------------------------------------
interface iirl_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iirl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirl_cell: one slot of the list
// Holds one entry and decides locally whether to keep it, take the write
// data, take its lower neighbor (insert) or its upper neighbor (remove).
// ----------------------------------------------------------------------------
module iirl_cell #(
  parameter int unsigned DATA_WIDTH = iirl_pkg::DATA_WIDTH_DEF,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  iirl_pkg::cell_cmd_t   cmd_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic [DATA_WIDTH-1:0] rdata_o
);
  import iirl_pkg::*;

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic [31:0]           pos_ext;
  logic                  hit, above;

  assign pos_ext = 32'(cmd_i.pos);
  assign hit     = (pos_ext == INDEX);
  assign above   = (pos_ext < INDEX);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.en) begin
      case (cmd_i.op)
        OP_SET: begin
          if (hit) entry_d = wdata_i;
        end
        OP_ADD: begin
          if (hit) entry_d = wdata_i;
          else if (above) entry_d = prev_i;
        end
        OP_REMOVE: begin
          if (hit || above) entry_d = next_i;
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Only the addressed cell puts its entry on the read bus.
  assign rdata_o = hit ? entry_q : '0;

endmodule
`default_nettype wire

FILE: rtl/core/indexed_insert_remove_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_insert_remove_list: bounded ordered list with indexed access
// Top level: request decode, range checks, entry count, row of storage
// cells and the registered response stage.
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY signed entries in a row of cells, one entry
// per cell, plus a count of valid entries. Each request transaction is a
// get, set, insert (add) or remove at a position, and yields exactly one
// response transaction carrying the read, old or removed value, a status
// (ok, index out of range, list full) and the count after the request.
// A request is decoded, checked against the count and applied in the cycle
// it is accepted: every cell compares its own slot number with the
// broadcast position and, in that same cycle, keeps its entry, takes the
// write data, or takes the entry of its lower or upper neighbor, so an
// insert or remove shifts the whole tail in parallel. The response appears
// in the cycle after acceptance, in an output register. A new request is
// accepted every cycle, also while a response waits, as long as that
// response is taken in the same cycle; so the block sustains one
// transaction per clock while responses are taken; an OR tree gathers the
// addressed entry. Flagged requests leave the list and count unchanged
// and return a value of zero. Entries are not cleared at reset, and there
// is no clearing pass: only entries below the count are ever read. With
// CAPACITY above 127 the count field reports the count modulo 128.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list #(
  parameter int unsigned CAPACITY   = iirl_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = iirl_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  iirl_stream_if.sink   req_i,
  iirl_stream_if.source rsp_o
);
  import iirl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request side.
  req_t                  req;
  op_e                   op;
  logic                  accept;
  logic [CMP_W-1:0]      pos_cmp, cnt_cmp;
  logic                  in_range, add_in_range, full;
  status_e               status;
  logic signed [63:0]    vin_ext;
  logic [DATA_WIDTH-1:0] wdata;

  // Entry count.
  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] count_wide;

  // Cell row.
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] entry  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_hit [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_any;
  logic signed [63:0]    rd_ext;

  // Response stage.
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  assign req    = req_i.data;
  assign op     = op_e'(req.req_type);
  assign accept = req_i.valid && req_i.ready;

  // A waiting response does not block a new request if it leaves this cycle.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  // Range checks. Since the count never exceeds CAPACITY, a position below
  // the count is also below CAPACITY.
  assign pos_cmp      = CMP_W'(req.position);
  assign cnt_cmp      = CMP_W'(count_q);
  assign in_range     = pos_cmp < cnt_cmp;
  assign add_in_range = pos_cmp <= cnt_cmp;
  assign full         = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    status = ST_OK;
    case (op)
      OP_ADD: begin
        if (!add_in_range) status = ST_RANGE;
        else if (full) status = ST_FULL;
      end
      OP_GET, OP_SET, OP_REMOVE: begin
        if (!in_range) status = ST_RANGE;
      end
      default: status = ST_OK;
    endcase
  end

  // The input value is sign extended and kept in its low DATA_WIDTH bits.
  assign vin_ext = 64'($signed(req.value_in));
  assign wdata   = vin_ext[DATA_WIDTH-1:0];

  assign cmd.en  = accept && (status == ST_OK) && (op != OP_GET);
  assign cmd.op  = op;
  assign cmd.pos = req.position;

  // Row of cells. The first cell's lower neighbor is never used, and the
  // last cell keeps its own entry when the tail moves down.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;

    if (k == 0) begin : g_first
      assign prev_data = wdata;
    end else begin : g_mid_lo
      assign prev_data = entry[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign next_data = entry[k];
    end else begin : g_mid_hi
      assign next_data = entry[k+1];
    end

    iirl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .wdata_i (wdata),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .entry_o (entry[k]),
      .rdata_o (rd_hit[k])
    );
  end

  // At most one cell drives a nonzero read value, so an OR gathers it.
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_hit[k];
    end
  end

  assign rd_ext = 64'($signed(rd_any));

  always_comb begin
    count_d = count_q;
    if (cmd.en) begin
      if (op == OP_ADD) count_d = count_q + CNT_W'(1);
      else if (op == OP_REMOVE) count_d = count_q - CNT_W'(1);
    end
  end

  assign count_wide = CMP_W'(count_d);

  always_comb begin
    rsp_d.value_out = '0;
    if (status == ST_OK && op != OP_ADD) rsp_d.value_out = rd_ext[VAL_W-1:0];
    rsp_d.status = status;
    rsp_d.count  = count_wide[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // The count only moves on successful inserts and removes.
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.en && op == OP_ADD) |=> (count_q == CNT_W'($past(count_q) + CNT_W'(1))))
    else $error("count did not grow after an accepted insert");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.en && op == OP_REMOVE) |=> (count_q == CNT_W'($past(count_q) - CNT_W'(1))))
    else $error("count did not shrink after an accepted remove");

  a_flagged_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status != ST_OK) |=> $stable(count_q))
    else $error("flagged request changed the count");

  a_full_only_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status == ST_FULL) |-> (count_q == CNT_W'(CAPACITY) && op == OP_ADD))
    else $error("full status reported below capacity");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (CMP_W'(count_q) <= CMP_W'(CAPACITY)))
    else $error("count exceeds capacity");

endmodule
`default_nettype wire

FILE: test/indexed_insert_remove_list_test.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_test: self-checking bench for the indexed list
// Drives get, set, insert and remove requests through the request channel,
// keeps a shadow copy of the list to work out every response, and compares
// each response transaction field by field under varying idle and stall.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iirl_pkg::*;

  localparam int unsigned SLOTS        = CAPACITY_DEF;
  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Shadow of the list contents. Each accepted request is applied here in
  // acceptance order, and the response it must produce is queued.
  class list_shadow;
    logic signed [VAL_W-1:0] slots [SLOTS];
    int unsigned             fill;
    rsp_t                    replies_owed [$];
    int unsigned             mismatches;
    int unsigned             replies_checked;
    int unsigned             range_flags;
    int unsigned             full_flags;
    int unsigned             peak_fill;

    function new();
      fill            = 0;
      mismatches      = 0;
      replies_checked = 0;
      range_flags     = 0;
      full_flags      = 0;
      peak_fill       = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void apply_request(req_t req);
      rsp_t        reply;
      op_e         op;
      int unsigned pos;
      op              = op_e'(req.req_type);
      pos             = req.position;
      reply.value_out = '0;
      reply.status    = ST_OK;
      case (op)
        OP_GET: begin
          if (pos >= fill) reply.status = ST_RANGE;
          else reply.value_out = slots[pos];
        end
        OP_SET: begin
          if (pos >= fill) begin
            reply.status = ST_RANGE;
          end else begin
            reply.value_out = slots[pos];
            slots[pos]      = req.value_in;
          end
        end
        OP_ADD: begin
          // The range check wins over the full check.
          if (pos > fill) begin
            reply.status = ST_RANGE;
          end else if (fill >= SLOTS) begin
            reply.status = ST_FULL;
          end else begin
            for (int j = fill; j > pos; j--) slots[j] = slots[j-1];
            slots[pos] = req.value_in;
            fill++;
          end
        end
        default: begin
          if (pos >= fill) begin
            reply.status = ST_RANGE;
          end else begin
            reply.value_out = slots[pos];
            for (int j = pos; j + 1 < fill; j++) slots[j] = slots[j+1];
            fill--;
          end
        end
      endcase
      reply.count = fill[CNT_OUT_W-1:0];
      if (reply.status == ST_RANGE) range_flags++;
      if (reply.status == ST_FULL) full_flags++;
      if (fill > peak_fill) peak_fill = fill;
      replies_owed.push_back(reply);
    endfunction

    task check_reply(rsp_t got);
      rsp_t want;
      if (replies_owed.size() == 0) begin
        report_mismatch($sformatf("response with none pending, value_out %0d status %0d",
                                  got.value_out, got.status));
        return;
      end
      want = replies_owed.pop_front();
      replies_checked++;
      if (got.value_out !== want.value_out)
        report_mismatch($sformatf("response %0d value_out %0d, want %0d",
                                  replies_checked, got.value_out, want.value_out));
      if (got.status !== want.status)
        report_mismatch($sformatf("response %0d status %0d, want %0d",
                                  replies_checked, got.status, want.status));
      if (got.count !== want.count)
        report_mismatch($sformatf("response %0d count %0d, want %0d",
                                  replies_checked, got.count, want.count));
    endtask
  endclass

  logic clk;
  logic rst_n;

  iirl_stream_if #(.item_t(req_t)) req_if ();
  iirl_stream_if #(.item_t(rsp_t)) rsp_if ();

  indexed_insert_remove_list dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  list_shadow  shadow = new();
  int unsigned gap_pct   = 0;   // chance in percent of an idle cycle before a request
  int unsigned stall_pct = 0;   // chance in percent of holding ready low
  int unsigned cycle_count = 0;
  bit          growing = 1'b1;  // random part trends toward inserts while set

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Response side backpressure. Ready is redrawn at every falling edge, so a
  // stall can land on any cycle, including the one right after acceptance.
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor. Both channels are sampled at the rising edge. The response is
  // checked before the request of the same edge is applied; the block's
  // response for that request is registered and only shows up later anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) shadow.check_reply(rsp_if.data);
      if (req_if.valid && req_if.ready) shadow.apply_request(req_if.data);
    end
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses still pending.",
               cycle_count, shadow.replies_owed.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one request transaction. Called at a falling edge; returns at the
  // falling edge after the transaction was accepted, with valid still high,
  // so back-to-back requests keep valid asserted without a glitch.
  task automatic send(req_t req);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(op_e op, int unsigned pos, logic [VAL_W-1:0] value);
    req_t req;
    req.req_type = op;
    req.position = pos[POS_W-1:0];
    req.value_in = value;
    send(req);
  endtask

  // Draw a random request. Most requests are well-formed for the current
  // fill level so the list really moves between empty and full; the rest hit
  // positions at or past the end, or anywhere in the 7-bit field.
  function automatic req_t pick_request(int unsigned fill);
    req_t        req;
    op_e         op;
    int unsigned roll;
    int unsigned pos;
    roll = $urandom_range(99);
    if (roll < 70)      op = growing ? OP_ADD : OP_REMOVE;
    else if (roll < 78) op = growing ? OP_REMOVE : OP_ADD;
    else if (roll < 89) op = OP_GET;
    else                op = OP_SET;

    roll = $urandom_range(99);
    if (roll < 8)        pos = $urandom_range(2**POS_W - 1);
    else if (roll < 16)  pos = fill;          // one past the last entry
    else if (roll < 24)  pos = 0;
    else if (op == OP_ADD) pos = $urandom_range(fill);
    else pos = (fill == 0) ? 0 : $urandom_range(fill - 1);
    // On a full list, also try inserts beyond the end: range beats full.
    if (op == OP_ADD && fill == SLOTS && $urandom_range(3) == 0)
      pos = $urandom_range(2**POS_W - 1, SLOTS + 1);

    req.req_type = op;
    req.position = pos[POS_W-1:0];
    case ($urandom_range(19))
      0:       req.value_in = {1'b1, {(VAL_W-1){1'b0}}};
      1:       req.value_in = {1'b0, {(VAL_W-1){1'b1}}};
      2:       req.value_in = '0;
      3:       req.value_in = '1;
      default: req.value_in = $urandom;
    endcase
    return req;
  endfunction

  initial begin
    int unsigned gap_by_phase   [4] = '{0, 66, 0, 6};
    int unsigned stall_by_phase [4] = '{0, 0, 66, 6};

    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, starting from the empty list. Every get, set or remove on
    // an empty list is out of range, as is an insert past the count.
    send_op(OP_GET,    0,   32'd5);
    send_op(OP_SET,    0,   32'd6);
    send_op(OP_REMOVE, 0,   32'd0);
    send_op(OP_ADD,    1,   32'd7);
    send_op(OP_ADD,    127, 32'd8);
    // Build [-1, 0, max, min] through front, end and middle inserts.
    send_op(OP_ADD,    0,   32'h7fff_ffff);
    send_op(OP_ADD,    1,   32'h8000_0000);
    send_op(OP_ADD,    0,   32'hffff_ffff);
    send_op(OP_ADD,    1,   32'h0000_0000);
    send_op(OP_GET,    0,   32'd0);
    send_op(OP_GET,    3,   32'd0);
    send_op(OP_GET,    4,   32'd0);
    // A set hands back the old entry.
    send_op(OP_SET,    2,   32'd12345);
    send_op(OP_SET,    127, 32'd1);
    // Remove from the middle, then the last entry, then past the end.
    send_op(OP_REMOVE, 1,   32'd0);
    send_op(OP_REMOVE, 2,   32'd0);
    send_op(OP_REMOVE, 64,  32'd0);
    send_op(OP_GET,    1,   32'd0);
    // Drain back to empty from the front.
    send_op(OP_REMOVE, 0,   32'd0);
    send_op(OP_REMOVE, 0,   32'd0);
    send_op(OP_GET,    0,   32'd0);

    // Random part in four idle phases: none, sender idle, receiver stall,
    // and a light mix of both. The trend flips a few requests after the list
    // hits full or empty, so both boundaries are exercised many times.
    for (int phase = 0; phase < 4; phase++) begin
      gap_pct   = gap_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      repeat (PHASE_ITEMS) begin
        if (growing && shadow.fill == SLOTS && $urandom_range(3) == 0) growing = 1'b0;
        else if (!growing && shadow.fill == 0 && $urandom_range(3) == 0) growing = 1'b1;
        else if ($urandom_range(99) == 0) growing = !growing;
        send(pick_request(shadow.fill));
      end
    end
    req_if.valid <= 1'b0;

    // Wait for every owed response, then give stray responses time to show.
    while (shadow.replies_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses: %0d out-of-range and %0d list-full flags.",
             shadow.replies_checked, shadow.range_flags, shadow.full_flags);
    $display("Peak fill %0d of %0d entries, %0d mismatches, %0d cycles.",
             shadow.peak_fill, SLOTS, shadow.mismatches, cycle_count);
    if (shadow.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/iirl_pkg.sv
rtl/core/iirl_stream_if.sv
rtl/core/iirl_cell.sv
rtl/core/indexed_insert_remove_list.sv
test/indexed_insert_remove_list_test.sv
